### src/stq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stq_pkg: shared types and constants for the sorted timer queue
// Opcodes, result kinds, slot states and default sizes.
// ----------------------------------------------------------------------------
package stq_pkg;

  localparam int unsigned DefSlots = 32;
  localparam int unsigned MaxResults = 32;
  localparam logic [31:0] NearestNone = 32'hffff_ffff;

  typedef enum logic [2:0] {
    OP_ALLOC   = 3'd0,
    OP_FREE    = 3'd1,
    OP_INIT    = 3'd2,
    OP_SETTIME = 3'd3,
    OP_TICK    = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_GRANT  = 2'd0,
    KIND_FAIL   = 2'd1,
    KIND_EXPIRY = 2'd2,
    KIND_MISUSE = 2'd3
  } kind_t;

  localparam logic [1:0] ST_FREE  = 2'd0;
  localparam logic [1:0] ST_ALLOC = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;

  // One result beat handed from the sequencer to the output register.
  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  slot;
    logic [7:0]  queue;
    logic [31:0] data;
    logic        last;
  } result_t;

endpackage
`default_nettype wire

### src/stq_out_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stq_out_reg: output register for result beats
// Holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module stq_out_reg
  import stq_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire result_t din,
  output logic         full,
  output logic         out_valid,
  input  wire logic    out_stall,
  output result_t      dout
);

  // Load on push, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (push) begin
      full <= 1'b1;
    end else if (full && !out_stall) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      dout <= din;
    end
  end

  assign out_valid = full;

  // Never overwrite a beat still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    push |-> !full || !out_stall)
    else $error("result overwritten");

endmodule
`default_nettype wire

### src/stq_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stq_core: timer slot store and list sequencer
// Keeps slot records in synchronous memories and walks the deadline list
// one link per read for insertion and expiry.
// ----------------------------------------------------------------------------
module stq_core
  import stq_pkg::*;
#(
  parameter int unsigned SLOTS = DefSlots
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  opcode,
  input  wire logic [4:0]  slot,
  input  wire logic [7:0]  queue_id,
  input  wire logic [31:0] payload,
  input  wire logic [31:0] delay,
  output logic             push,
  output result_t          res,
  input  wire logic        res_full
);

  localparam int unsigned SW = $clog2(SLOTS);
  localparam int unsigned LW = SW + 1;
  localparam logic [LW-1:0] NIL = LW'(SLOTS);
  localparam int unsigned CW = $clog2(MaxResults + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_ALLOC, S_INS_RD, S_INS_CHK, S_INS_LNK, S_INS_LNK2,
    S_EXP_RD, S_EXP_CHK, S_EXP_END, S_WAIT
  } state_t;

  // Slot record memories
  logic [31:0]   deadline_mem [SLOTS];
  logic [7:0]    queue_mem    [SLOTS];
  logic [31:0]   data_mem     [SLOTS];
  logic [LW-1:0] link_mem     [SLOTS];
  logic [1:0]    status       [SLOTS];

  state_t        state;
  logic [LW-1:0] head;
  logic [31:0]   nearest;
  logic [31:0]   tick_count;
  logic [LW-1:0] cur;
  logic [LW-1:0] prev;
  logic [SW-1:0] tgt;
  logic [31:0]   due;
  logic [SW:0]   scan;
  logic [CW-1:0] n_out;
  result_t       hold;
  logic          hold_v;
  logic [31:0]   rd_dl;
  logic [7:0]    rd_q;
  logic [31:0]   rd_d;
  logic [LW-1:0] rd_lnk;
  logic [SW-1:0] rd_addr;
  logic          rd_en;
  logic          ln_we;
  logic [SW-1:0] ln_addr;
  logic [LW-1:0] ln_val;
  logic          hit;
  logic [31:0]   tick_next;
  logic          acc;
  logic          run_hit;
  logic          exp_due;
  logic          res_room;
  logic          alloc_done;
  logic          push_next;

  assign hit = (SLOTS >= 32) || (32'(slot) < SLOTS);
  assign tick_next = tick_count + 32'd1;

  // Registered reads of the slot records
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_dl  <= deadline_mem[rd_addr];
      rd_q   <= queue_mem[rd_addr];
      rd_d   <= data_mem[rd_addr];
      rd_lnk <= link_mem[rd_addr];
    end
  end

  // Record writes
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid && !in_stall && hit && opcode == OP_INIT) begin
      queue_mem[SW'(slot)] <= queue_id;
      data_mem[SW'(slot)]  <= payload;
    end
    if (state == S_INS_LNK) begin
      deadline_mem[tgt] <= due;
    end
    if (ln_we) begin
      link_mem[ln_addr] <= ln_val;
    end
  end

  // Read address and link writes: own link first, then the predecessor
  always_comb begin
    rd_en   = (state == S_INS_RD) || (state == S_EXP_RD);
    rd_addr = cur[SW-1:0];
    ln_we   = (state == S_INS_LNK) || (state == S_INS_LNK2);
    ln_addr = (state == S_INS_LNK2) ? prev[SW-1:0] : tgt;
    ln_val  = (state == S_INS_LNK2) ? LW'(tgt) : cur;
  end

  // Decide when a result beat goes to the output register
  always_comb begin
    acc        = (state == S_IDLE) && in_valid && !in_stall;
    run_hit    = hit && (status[SW'(slot)] == ST_RUN);
    exp_due    = (n_out != CW'(MaxResults)) && (rd_dl <= tick_count);
    res_room   = !res_full && !push;
    alloc_done = (status[scan[SW-1:0]] == ST_FREE) || (scan == (SW+1)'(SLOTS - 1));
    push_next  = (acc && run_hit && (opcode == OP_FREE || opcode == OP_SETTIME)) ||
                 (state == S_ALLOC && alloc_done) ||
                 (state == S_EXP_CHK && exp_due && hold_v && res_room) ||
                 (state == S_EXP_END && hold_v && res_room);
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= NIL;
      nearest    <= NearestNone;
      tick_count <= '0;
      push       <= 1'b0;
      hold_v     <= 1'b0;
      for (int i = 0; i < int'(SLOTS); i++) status[i] <= ST_FREE;
    end else begin
      push <= push_next;
      unique case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            tgt <= SW'(slot);
            unique case (opcode)
              OP_ALLOC: begin
                scan  <= '0;
                state <= S_ALLOC;
              end
              OP_FREE: if (hit) begin
                if (run_hit) begin
                  res   <= '{KIND_MISUSE, slot, 8'd0, 32'd0, 1'b1};
                  state <= S_WAIT;
                end else begin
                  status[SW'(slot)] <= ST_FREE;
                end
              end
              OP_SETTIME: if (hit) begin
                if (run_hit) begin
                  res   <= '{KIND_MISUSE, slot, 8'd0, 32'd0, 1'b1};
                  state <= S_WAIT;
                end else begin
                  status[SW'(slot)] <= ST_RUN;
                  due   <= delay + tick_count;
                  cur   <= head;
                  prev  <= NIL;
                  scan  <= '0;
                  state <= S_INS_RD;
                end
              end
              OP_TICK: begin
                tick_count <= tick_next;
                if (nearest <= tick_next) begin
                  cur   <= head;
                  n_out <= '0;
                  state <= S_EXP_RD;
                end
              end
              default: ;
            endcase
          end
        end
        // Find lowest free slot, one per cycle
        S_ALLOC: begin
          if (status[scan[SW-1:0]] == ST_FREE) begin
            status[scan[SW-1:0]] <= ST_ALLOC;
            res   <= '{KIND_GRANT, 5'(scan), 8'd0, 32'd0, 1'b1};
            state <= S_WAIT;
          end else if (scan == (SW+1)'(SLOTS - 1)) begin
            res   <= '{KIND_FAIL, 5'd0, 8'd0, 32'd0, 1'b1};
            state <= S_WAIT;
          end else begin
            scan <= scan + 1'b1;
          end
        end
        // Walk list for insertion point
        S_INS_RD: begin
          if (cur == NIL || scan == (SW+1)'(SLOTS)) state <= S_INS_LNK;
          else state <= S_INS_CHK;
        end
        S_INS_CHK: begin
          if (rd_dl < due) begin
            prev  <= cur;
            cur   <= rd_lnk;
            scan  <= scan + 1'b1;
            state <= S_INS_RD;
          end else begin
            state <= S_INS_LNK;
          end
        end
        // Link the new entry, then its predecessor unless it becomes head
        S_INS_LNK: begin
          if (prev == NIL) begin
            head    <= LW'(tgt);
            nearest <= due;
            state   <= S_IDLE;
          end else begin
            state <= S_INS_LNK2;
          end
        end
        S_INS_LNK2: begin
          state <= S_IDLE;
        end
        // Expiry walk; hold each beat until the next entry tells if it is last
        S_EXP_RD: begin
          if (cur == NIL) begin
            head    <= NIL;
            nearest <= NearestNone;
            state   <= S_EXP_END;
          end else begin
            state <= S_EXP_CHK;
          end
        end
        S_EXP_CHK: begin
          if (!exp_due) begin
            head    <= cur;
            nearest <= rd_dl;
            state   <= S_EXP_END;
          end else if (!hold_v || res_room) begin
            if (hold_v) res <= hold;
            hold   <= '{KIND_EXPIRY, 5'(cur), rd_q, rd_d, 1'b0};
            hold_v <= 1'b1;
            status[cur[SW-1:0]] <= ST_ALLOC;
            n_out  <= n_out + 1'b1;
            cur    <= rd_lnk;
            state  <= S_EXP_RD;
          end
        end
        // Send the held beat marked last, if any
        S_EXP_END: begin
          if (!hold_v) begin
            state <= S_IDLE;
          end else if (res_room) begin
            res    <= '{hold.kind, hold.slot, hold.queue, hold.data, 1'b1};
            hold_v <= 1'b0;
            state  <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (!res_full && !push) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_stall = (state != S_IDLE) || res_full;

  // Busy sequencer always holds off the input
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall)
    else $error("input not stalled while busy");

  // Push only into an empty output register
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !res_full)
    else $error("push into full output register");

  // Head is a slot or the empty mark
  a_head_range: assert property (@(posedge clk) disable iff (rst)
    head <= NIL)
    else $error("head out of range");

  // No beat left behind when idle
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !hold_v)
    else $error("held beat left in idle");

endmodule
`default_nettype wire

### src/sorted_timer_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_timer_queue: timer slot pool with a deadline-ordered list
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall, one beat carries opcode, slot, queue_id,
// payload and delay. Result channel: out_valid/out_stall, one beat carries
// kind, out_slot, out_queue, out_data and last (set on the final beat of an
// input). Items are handled one at a time; in_stall stays high while busy.
// Init, plain free, unused opcodes and a tick with nothing due finish in the
// idle state, so such beats can follow back to back. Alloc: slots are scanned
// upward from slot 0; the lowest free slot is granted, else a failure result
// is given. Misuse: the result is registered in the sequencer and then in the
// output register. Settime: the walk reads each listed entry with an earlier
// deadline, then links the new entry and, unless it becomes head, its
// predecessor. Tick with due timers: the walk reads each list entry in turn
// and holds each due beat until the next entry shows whether it is last.
// After a result the input stays stalled until the last beat is taken and the
// sequencer is back in idle. A receiver stall holds the beat in the output
// register and pauses the walk. Reset empties the list, frees all slots and
// clears count.
// ----------------------------------------------------------------------------
module sorted_timer_queue
  import stq_pkg::*;
#(
  parameter int unsigned SLOTS = DefSlots
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  opcode,
  input  wire logic [4:0]  slot,
  input  wire logic [7:0]  queue_id,
  input  wire logic [31:0] payload,
  input  wire logic [31:0] delay,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       kind,
  output logic [4:0]       out_slot,
  output logic [7:0]       out_queue,
  output logic [31:0]      out_data,
  output logic             last
);
  logic    push, full;
  result_t res, dout;

  stq_core #(.SLOTS(SLOTS)) u_core (
    .clk, .rst, .in_valid, .in_stall, .opcode, .slot, .queue_id, .payload,
    .delay, .push, .res, .res_full(full)
  );

  stq_out_reg u_out (
    .clk, .rst, .push, .din(res), .full, .out_valid, .out_stall, .dout
  );

  assign kind = dout.kind;
  assign out_slot = dout.slot;
  assign out_queue = dout.queue;
  assign out_data = dout.data;
  assign last = dout.last;
endmodule
`default_nettype wire
